// File: rtl/core/regex_followpos_builder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the followpos builder
// Shared check forms, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef REGEX_FOLLOWPOS_BUILDER_TOP_MACROS_SVH
`define REGEX_FOLLOWPOS_BUILDER_TOP_MACROS_SVH

// condition holds on every edge
`define RFB_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define RFB_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define RFB_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/rfb_pkg.sv
// ----------------------------------------------------------------------------
// Followpos builder package
// Sizes, character codes, operator and class codes, sequencer states.
// ----------------------------------------------------------------------------
package rfb_pkg;

	localparam int MAX_POSITIONS = 64;
	localparam int STACK_DEPTH   = 16;

	localparam logic [7:0] ESC_RESET = 8'd92;
	localparam logic [7:0] CH_CLOSE  = 8'h29;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_CAT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [2:0] {
		OP_BAR  = 3'd1,
		OP_CAT  = 3'd2,
		OP_STAR = 3'd3,
		OP_OPEN = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		PR_LIT   = 3'd0,
		PR_CLOSE = 3'd1,
		PR_BAR   = 3'd2,
		PR_CAT   = 3'd3,
		PR_STAR  = 3'd4,
		PR_OPEN  = 3'd5
	} class_t;

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_SYM,
		PH_CLOSE,
		PH_DOT,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		RET_CAT,
		RET_MAIN,
		RET_END
	} ret_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FEED,
		ST_MAIN,
		ST_RED_CHK,
		ST_RED_RDR,
		ST_RED_GOT,
		ST_LINK,
		ST_ELEM_WR,
		ST_NEXT,
		ST_END,
		ST_FIN,
		ST_ROOT_GOT,
		ST_OUT_RD,
		ST_OUT_EM,
		ST_ERR_EM
	} state_t;

	function automatic class_t class_of(input logic [7:0] c);
		class_t r;
		case (c)
			CH_CLOSE: r = PR_CLOSE;
			CH_BAR:   r = PR_BAR;
			CH_CAT:   r = PR_CAT;
			CH_STAR:  r = PR_STAR;
			CH_OPEN:  r = PR_OPEN;
			default:  r = PR_LIT;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/regex_followpos_builder_top.sv
// ----------------------------------------------------------------------------
// Regular expression followpos builder
// Operator-precedence parse of an expression fed one character per beat,
// building first/last sets and the followpos matrix.
// ----------------------------------------------------------------------------
// Use: pulse start with symbol and final_req while busy is low; the beat is
// taken on that edge and busy rises. escape_char_we writes the escape code
// (reset 92); the user must only use it between expressions; not enforced.
// An escape character is only noted for the character after it; any other
// character is parsed (the first of an expression also feeds an implied open),
// and each alternation, star and concatenation reduced adds steps; every
// followpos update walks all MaxPos rows of the matrix RAM through its
// single read/write port pair, one row a cycle.
// A final character then closes the expression, and results follow one per
// position: done is high one cycle per result, last on the final
// one. A malformed or overflowing expression gives one result with error set.
// The receiver cannot stall; results are shown exactly once each.
// Reset clears all control state; the matrix rows are cleared by valid bits
// at the first character of every expression, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "regex_followpos_builder_top_macros.svh"

module regex_followpos_builder_top #(
	parameter int MaxPos     = rfb_pkg::MAX_POSITIONS,
	parameter int StackDepth = rfb_pkg::STACK_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      escape_char_we,
	input  logic [7:0]                escape_char,
	input  logic                      start,
	input  logic [7:0]                symbol,
	input  logic                      final_req,
	output logic                      busy,
	output logic                      done,
	output logic [$clog2(MaxPos)-1:0] position,
	output logic [7:0]                pos_symbol,
	output logic                      end_marker,
	output logic [MaxPos-1:0]         follow_set,
	output logic                      in_first,
	output logic                      error,
	output logic                      last
);
	import rfb_pkg::*;

	localparam int IW  = $clog2(MaxPos);
	localparam int PCW = $clog2(MaxPos + 1);
	localparam int SW  = $clog2(StackDepth);
	localparam int SCW = $clog2(StackDepth + 1);
	localparam int EW  = 2 * MaxPos + 1;

	state_t state_q, state_d;
	phase_t phase_q;
	ret_t   ret_q;
	class_t pr_q, prio_q, f_pr;
	op_t    red_op_q, top_op;
	op_t    op_stack_q [StackDepth];

	logic [7:0]        esc_q, sym_q, ch_q, f_ch;
	logic              started_q, fin_q, escp_q, err_q, connect_q, closing_q;
	logic [SCW-1:0]    op_cnt_q, elem_cnt_q, op_m1, ec_m1, ec_m2;
	logic [PCW-1:0]    pos_cnt_q, link_cnt_q, link_m1;
	logic [MaxPos-1:0] row_vld_q, pre_q, post_q, root_q, leaf_bit;
	logic [MaxPos-1:0] r_first_q, r_last_q, l_first, l_last;
	logic              r_null_q, l_null;
	logic [EW-1:0]     ewr_q;
	logic [SW-1:0]     ewr_addr_q;
	logic [IW-1:0]     out_p_q, link_w;

	logic              accept, f_skip, f_lit, f_catins;
	logic              red_ok, red_fail, red_go, red_pop, op_full, leaf_ok;
	logic              end_ok, res_err, out_last;

	logic              e_we, r_we, s_we;
	logic [SW-1:0]     e_waddr, e_raddr;
	logic [EW-1:0]     e_wdata, e_rdata;
	logic [IW-1:0]     r_waddr, r_raddr, s_waddr;
	logic [MaxPos-1:0] r_wdata, r_rdata;
	logic [7:0]        s_wdata, s_rdata;

	rfb_ram #(.Width(EW), .Depth(StackDepth)) u_elem_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	rfb_ram #(.Width(MaxPos), .Depth(MaxPos)) u_row_ram (
		.clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	rfb_ram #(.Width(8), .Depth(MaxPos)) u_sym_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(out_p_q), .rdata(s_rdata)
	);

	// decode
	always_comb begin
		accept   = start && (state_q == ST_IDLE);
		op_m1    = op_cnt_q - 1'b1;
		ec_m1    = elem_cnt_q - 1'b1;
		ec_m2    = elem_cnt_q - SCW'(2);
		link_m1  = link_cnt_q - 1'b1;
		link_w   = link_m1[IW-1:0];
		top_op   = op_stack_q[op_m1[SW-1:0]];
		op_full  = (op_cnt_q >= SCW'(StackDepth));
		leaf_ok  = (pos_cnt_q < PCW'(MaxPos)) && (elem_cnt_q < SCW'(StackDepth));
		leaf_bit = MaxPos'(1) << pos_cnt_q[IW-1:0];
		l_first  = e_rdata[EW-1:MaxPos+1];
		l_last   = e_rdata[MaxPos:1];
		l_null   = e_rdata[0];
		end_ok   = (op_cnt_q == SCW'(1)) && (op_stack_q[0] == OP_CAT) &&
			(elem_cnt_q == SCW'(1));
		res_err  = err_q || (elem_cnt_q != SCW'(1)) || (pos_cnt_q == '0);
		out_last = (PCW'(out_p_q) == pos_cnt_q - 1'b1);

		f_ch  = sym_q;
		f_lit = 1'b0;
		f_skip = err_q;
		case (phase_q)
			PH_OPEN:  f_ch = CH_OPEN;
			PH_SYM: begin
				f_lit = escp_q;
				if (!escp_q && sym_q == esc_q) begin
					f_skip = 1'b1;
				end
			end
			PH_CLOSE: begin
				f_ch  = CH_CLOSE;
				f_lit = escp_q;
			end
			PH_DOT:   f_ch = CH_CAT;
			default:  f_ch = sym_q;
		endcase
		f_pr     = f_lit ? PR_LIT : class_of(f_ch);
		f_catins = connect_q && (f_pr == PR_LIT || f_pr == PR_OPEN);

		red_ok   = 1'b0;
		red_fail = 1'b0;
		red_go   = 1'b0;
		red_pop  = 1'b0;
		if (op_cnt_q == '0) begin
			red_ok = 1'b1;
		end else if (4'(top_op) + 4'd1 < 4'(prio_q)) begin
			red_ok = 1'b1;
		end else if (top_op == OP_OPEN) begin
			red_ok  = 1'b1;
			red_pop = closing_q;
		end else if (top_op == OP_STAR) begin
			red_fail = (elem_cnt_q == '0);
			red_go   = !red_fail;
		end else begin
			red_fail = (elem_cnt_q < SCW'(2));
			red_go   = !red_fail;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_FEED;
			end
			ST_FEED: begin
				if (phase_q == PH_END) state_d = ST_END;
				else if (f_skip) state_d = ST_NEXT;
				else if (f_catins) state_d = ST_RED_CHK;
				else state_d = ST_MAIN;
			end
			ST_MAIN: begin
				state_d = (pr_q == PR_LIT) ? ST_NEXT : ST_RED_CHK;
			end
			ST_RED_CHK: begin
				if (red_go) begin
					state_d = ST_RED_RDR;
				end else if (red_fail) begin
					state_d = (ret_q == RET_END) ? ST_FIN : ST_NEXT;
				end else begin
					case (ret_q)
						RET_CAT: state_d = op_full ? ST_NEXT : ST_MAIN;
						RET_END: state_d = ST_FIN;
						default: state_d = ST_NEXT;
					endcase
				end
			end
			ST_RED_RDR: state_d = (red_op_q == OP_STAR) ? ST_LINK : ST_RED_GOT;
			ST_RED_GOT: state_d = (red_op_q == OP_CAT) ? ST_LINK : ST_ELEM_WR;
			ST_LINK: begin
				if (link_cnt_q == PCW'(MaxPos)) state_d = ST_ELEM_WR;
			end
			ST_ELEM_WR: state_d = ST_RED_CHK;
			ST_NEXT: begin
				if (phase_q == PH_SYM && !fin_q) state_d = ST_IDLE;
				else state_d = ST_FEED;
			end
			ST_END: begin
				state_d = (!err_q && end_ok && leaf_ok) ? ST_RED_CHK : ST_FIN;
			end
			ST_FIN:      state_d = res_err ? ST_ERR_EM : ST_ROOT_GOT;
			ST_ROOT_GOT: state_d = ST_OUT_RD;
			ST_OUT_RD:   state_d = ST_OUT_EM;
			ST_OUT_EM:   state_d = out_last ? ST_IDLE : ST_OUT_RD;
			ST_ERR_EM:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory ports and results
	always_comb begin
		e_we    = 1'b0;
		e_waddr = elem_cnt_q[SW-1:0];
		e_wdata = {leaf_bit, leaf_bit, 1'b0};
		e_raddr = ec_m1[SW-1:0];
		s_we    = 1'b0;
		s_waddr = pos_cnt_q[IW-1:0];
		s_wdata = ch_q;
		r_we    = 1'b0;
		r_waddr = link_w;
		r_wdata = (row_vld_q[link_w] ? r_rdata : '0) | post_q;
		r_raddr = out_p_q;
		case (state_q)
			ST_MAIN: begin
				e_we = (pr_q == PR_LIT) && leaf_ok;
				s_we = e_we;
			end
			ST_END: begin
				e_we    = !err_q && end_ok && leaf_ok;
				s_we    = e_we;
				s_wdata = CH_NUL;
			end
			ST_RED_RDR: e_raddr = ec_m2[SW-1:0];
			ST_FIN:     e_raddr = '0;
			ST_LINK: begin
				r_raddr = link_cnt_q[IW-1:0];
				r_we    = (link_cnt_q != '0) && pre_q[link_w];
			end
			ST_ELEM_WR: begin
				e_we    = 1'b1;
				e_waddr = ewr_addr_q;
				e_wdata = ewr_q;
			end
			default: e_raddr = ec_m1[SW-1:0];
		endcase

		busy       = (state_q != ST_IDLE);
		done       = (state_q == ST_OUT_EM) || (state_q == ST_ERR_EM);
		error      = (state_q == ST_ERR_EM);
		last       = done && (error || out_last);
		position   = (state_q == ST_OUT_EM) ? out_p_q : '0;
		pos_symbol = (state_q == ST_OUT_EM) ? s_rdata : '0;
		end_marker = (state_q == ST_OUT_EM) && out_last;
		follow_set = (state_q == ST_OUT_EM && row_vld_q[out_p_q]) ? r_rdata : '0;
		in_first   = (state_q == ST_OUT_EM) && root_q[out_p_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= PH_OPEN;
			ret_q      <= RET_CAT;
			pr_q       <= PR_LIT;
			prio_q     <= PR_LIT;
			red_op_q   <= OP_BAR;
			esc_q      <= ESC_RESET;
			started_q  <= 1'b0;
			fin_q      <= 1'b0;
			escp_q     <= 1'b0;
			err_q      <= 1'b0;
			connect_q  <= 1'b0;
			closing_q  <= 1'b0;
			op_cnt_q   <= '0;
			elem_cnt_q <= '0;
			pos_cnt_q  <= '0;
			row_vld_q  <= '0;
			link_cnt_q <= '0;
			out_p_q    <= '0;
		end else begin
			state_q <= state_d;
			if (escape_char_we) begin
				esc_q <= escape_char;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fin_q     <= final_req;
						started_q <= 1'b1;
						phase_q   <= started_q ? PH_SYM : PH_OPEN;
						if (!started_q) begin
							op_cnt_q   <= '0;
							elem_cnt_q <= '0;
							pos_cnt_q  <= '0;
							connect_q  <= 1'b0;
							escp_q     <= 1'b0;
							err_q      <= 1'b0;
							row_vld_q  <= '0;
						end
					end
				end
				ST_FEED: begin
					if (phase_q == PH_SYM && !err_q) begin
						escp_q <= !escp_q && (sym_q == esc_q);
					end
					if (phase_q == PH_CLOSE) begin
						escp_q <= 1'b0;
					end
					pr_q      <= f_pr;
					prio_q    <= PR_CAT;
					closing_q <= 1'b0;
					ret_q     <= RET_CAT;
				end
				ST_MAIN: begin
					if (pr_q == PR_LIT) begin
						connect_q <= 1'b1;
						if (leaf_ok) begin
							pos_cnt_q  <= pos_cnt_q + 1'b1;
							elem_cnt_q <= elem_cnt_q + 1'b1;
						end else begin
							err_q <= 1'b1;
						end
					end else begin
						prio_q    <= pr_q;
						closing_q <= (pr_q == PR_CLOSE);
						ret_q     <= RET_MAIN;
					end
				end
				ST_RED_CHK: begin
					red_op_q   <= top_op;
					link_cnt_q <= '0;
					if (red_go) begin
						op_cnt_q <= op_m1;
					end else if (red_fail) begin
						err_q <= 1'b1;
					end else begin
						if (red_pop) begin
							op_cnt_q <= op_m1;
						end
						if (ret_q == RET_CAT || (ret_q == RET_MAIN && pr_q != PR_CLOSE)) begin
							if (op_full) err_q <= 1'b1;
							else op_cnt_q <= op_cnt_q + 1'b1;
						end
						if (ret_q == RET_MAIN) begin
							connect_q <= (pr_q == PR_STAR) || (pr_q == PR_CLOSE);
						end
					end
				end
				ST_LINK: begin
					link_cnt_q <= link_cnt_q + 1'b1;
					if (link_cnt_q != '0 && pre_q[link_w]) begin
						row_vld_q[link_w] <= 1'b1;
					end
				end
				ST_ELEM_WR: begin
					if (red_op_q != OP_STAR) begin
						elem_cnt_q <= ec_m1;
					end
				end
				ST_NEXT: begin
					case (phase_q)
						PH_OPEN:  phase_q <= PH_SYM;
						PH_SYM:   phase_q <= PH_CLOSE;
						PH_CLOSE: phase_q <= PH_DOT;
						default:  phase_q <= PH_END;
					endcase
				end
				ST_END: begin
					prio_q    <= PR_CAT;
					closing_q <= 1'b0;
					ret_q     <= RET_END;
					if (!err_q) begin
						if (end_ok && leaf_ok) begin
							pos_cnt_q  <= pos_cnt_q + 1'b1;
							elem_cnt_q <= elem_cnt_q + 1'b1;
						end else begin
							err_q <= 1'b1;
						end
					end
				end
				ST_FIN:      started_q <= 1'b0;
				ST_ROOT_GOT: out_p_q <= '0;
				ST_OUT_EM:   out_p_q <= out_p_q + 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= symbol;
		end
		case (state_q)
			ST_FEED: ch_q <= f_ch;
			ST_RED_CHK: begin
				if (red_ok && !red_fail && !op_full) begin
					if (ret_q == RET_CAT) begin
						op_stack_q[op_cnt_q[SW-1:0]] <= OP_CAT;
					end else if (ret_q == RET_MAIN && pr_q != PR_CLOSE) begin
						op_stack_q[op_cnt_q[SW-1:0]] <= op_t'(3'(pr_q) - 3'd1);
					end
				end
			end
			ST_RED_RDR: begin
				r_first_q  <= l_first;
				r_last_q   <= l_last;
				r_null_q   <= l_null;
				pre_q      <= l_last;
				post_q     <= l_first;
				ewr_q      <= {l_first, l_last, 1'b1};
				ewr_addr_q <= ec_m1[SW-1:0];
			end
			ST_RED_GOT: begin
				ewr_addr_q <= ec_m2[SW-1:0];
				pre_q      <= l_last;
				post_q     <= r_first_q;
				if (red_op_q == OP_CAT) begin
					ewr_q <= {l_first | (l_null ? r_first_q : '0),
						r_last_q | (r_null_q ? l_last : '0),
						l_null & r_null_q};
				end else begin
					ewr_q <= {l_first | r_first_q, l_last | r_last_q, l_null | r_null_q};
				end
			end
			ST_ROOT_GOT: root_q <= l_first;
			default: ;
		endcase
	end

	`RFB_ASSERT(a_op_bound, op_cnt_q <= SCW'(StackDepth), "operator stack count out of range")
	`RFB_ASSERT(a_pos_bound, pos_cnt_q <= PCW'(MaxPos), "position count out of range")
	`RFB_ASSERT_IMP(a_err_last, done && error, last, "error beat without last")
	`RFB_ASSERT_NXT(a_last_idle, done && last, !busy, "still busy after last beat")
	`RFB_ASSERT_IMP(a_link_end, state_q == ST_LINK, link_cnt_q <= PCW'(MaxPos),
		"link walk overran")

endmodule

// File: rtl/core/rfb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rfb_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
